// ----- hdl/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

    typedef enum logic [4:0] {
        K_DIGIT  = 5'd0,
        K_ENTER  = 5'd1,
        K_ESCAPE = 5'd2,
        K_BKSP   = 5'd3,
        K_ADD    = 5'd4,
        K_SUB    = 5'd5,
        K_MUL    = 5'd6,
        K_DIV    = 5'd7,
        K_AND    = 5'd8,
        K_OR     = 5'd9,
        K_XOR    = 5'd10,
        K_NOT    = 5'd11,
        K_NEG    = 5'd12,
        K_DOUBLE = 5'd13,
        K_HALVE  = 5'd14,
        K_SWAP   = 5'd15,
        K_ROLL   = 5'd16,
        K_OVER   = 5'd17,
        K_DROP   = 5'd18,
        K_DUP    = 5'd19,
        K_CLEAR  = 5'd20,
        K_RADIX  = 5'd21,
        K_PEEK   = 5'd22
    } cmd_kind_t;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_code_t;

    typedef enum logic [1:0] {
        RD_TOP    = 2'd0,
        RD_SECOND = 2'd1,
        RD_THIRD  = 2'd2,
        RD_PEEK   = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_PUSH   = 2'd0,
        WR_TOP    = 2'd1,
        WR_SECOND = 2'd2,
        WR_THIRD  = 2'd3
    } wr_off_t;

    typedef enum logic [2:0] {
        SRC_A   = 3'd0,
        SRC_B   = 3'd1,
        SRC_C   = 3'd2,
        SRC_ALU = 3'd3,
        SRC_MD  = 3'd4
    } wr_src_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } cnt_op_t;

    typedef enum logic [1:0] {
        MD_MUL  = 2'd0,
        MD_DIV  = 2'd1,
        MD_BKSP = 2'd2
    } md_sel_t;

    typedef struct packed {
        logic      load;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      cap_a;
        logic      cap_b;
        logic      cap_c;
        logic      cap_p;
        logic      wr_en;
        wr_off_t   wr_off;
        wr_src_t   wr_src;
        cnt_op_t   cnt_op;
        logic      set_closed;
        logic      clr_closed;
        logic      set_radix;
        logic      set_beep;
        logic      set_ignored;
        logic      md_start;
        md_sel_t   md_sel;
        logic      out_load;
    } rpn_cmd_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      cnt_zero;
        logic      cnt_ge2;
        logic      cnt_ge3;
        logic      cnt_full;
        logic      fresh;
        logic      closed;
        logic      a_zero;
        logic      digit_bad;
        logic      md_busy;
        logic      out_free;
    } rpn_status_t;

    function automatic logic [4:0] radix_value(input radix_code_t code);
        logic [4:0] v;
        unique case (code)
            RADIX_BIN: v = 5'd2;
            RADIX_OCT: v = 5'd8;
            RADIX_DEC: v = 5'd10;
            RADIX_HEX: v = 5'd16;
            default:   v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rpn_muldiv.sv -----
`default_nettype none

module rpn_muldiv
    import rpn_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 div,
    input  wire logic [WORD_BITS-1:0] opa,
    input  wire logic [WORD_BITS-1:0] opb,
    output logic                      busy,
    output logic [WORD_BITS-1:0]      result
);

    localparam int CNTW = $clog2(WORD_BITS + 1);

    logic                 busy_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic                 div_reg;
    logic                 neg_reg;
    logic [WORD_BITS:0]   trial;
    logic                 fits;

    function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    assign trial = {acc_reg, y_reg[WORD_BITS-1]};
    assign fits  = trial >= {1'b0, x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(WORD_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= div;
            acc_reg <= '0;
            if (div)
            begin
                x_reg   <= mag(opb);
                y_reg   <= mag(opa);
                neg_reg <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
            end
            else
            begin
                x_reg   <= opa;
                y_reg   <= opb;
                neg_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (fits)
                begin
                    acc_reg <= WORD_BITS'(trial - {1'b0, x_reg});
                end
                else
                begin
                    acc_reg <= trial[WORD_BITS-1:0];
                end
                y_reg <= {y_reg[WORD_BITS-2:0], fits};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[WORD_BITS-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[WORD_BITS-1:1]};
            end
        end
    end

    assign busy   = busy_reg;
    assign result = div_reg ? (neg_reg ? (~y_reg + 1'b1) : y_reg) : acc_reg;

endmodule

`default_nettype wire

// ----- hdl/rpn_dp.sv -----
`default_nettype none

module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_ENTRIES = 32,
    parameter int WORD_BITS     = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [4:0]  kind,
    input  wire logic [3:0]  digit_value,
    input  wire logic [1:0]  base_code,
    input  wire logic [4:0]  peek_index,
    input  wire rpn_cmd_t    cmd,
    output rpn_status_t      status,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic signed [31:0] top_value,
    output logic signed [31:0] peek_value,
    output logic             peek_valid,
    output logic [5:0]       stack_count,
    output logic             entering,
    output logic             beep,
    output logic             ignored
);

    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int CW = $clog2(STACK_ENTRIES + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam int XB = (WORD_BITS > 32) ? WORD_BITS : 32;

    logic [WORD_BITS-1:0] mem [STACK_ENTRIES];

    cmd_kind_t            kind_reg;
    logic [3:0]           digit_reg;
    radix_code_t          bcode_reg;
    logic [4:0]           idx_reg;
    logic [CW-1:0]        count_reg;
    radix_code_t          radix_reg;
    logic                 closed_reg;
    logic                 slot0_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rzero_reg;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] c_reg;
    logic [WORD_BITS-1:0] p_reg;
    logic                 pv_reg;
    logic                 beep_reg;
    logic                 ign_reg;
    logic                 out_valid_reg;
    logic [31:0]          top_value_reg;
    logic [31:0]          peek_value_reg;
    logic                 peek_valid_reg;
    logic [5:0]           stack_count_reg;
    logic                 entering_reg;
    logic                 beep_out_reg;
    logic                 ign_out_reg;

    logic [XW-1:0]        cnt_x;
    logic [XW-1:0]        rd_diff;
    logic [XW-1:0]        wr_diff;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] alu;
    logic [WORD_BITS-1:0] acc_base;
    logic [WORD_BITS-1:0] scaled;
    logic [WORD_BITS-1:0] md_opa;
    logic [WORD_BITS-1:0] md_opb;
    logic                 md_div;
    logic                 md_busy;
    logic [WORD_BITS-1:0] md_result;
    logic                 full;
    logic                 fresh;
    logic                 peek_ok;
    logic [XB-1:0]        top_ext;
    logic [XB-1:0]        peek_ext;
    logic [XW-1:0]        count_ext;

    assign cnt_x   = XW'(count_reg);
    assign full    = count_reg == CW'(STACK_ENTRIES);
    assign fresh   = (closed_reg || count_reg == '0) && !full;
    assign peek_ok = XW'(idx_reg) < cnt_x;
    assign rd_word = rzero_reg ? '0 : rdata_reg;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_TOP:    rd_diff = cnt_x - XW'(1);
            RD_SECOND: rd_diff = cnt_x - XW'(2);
            RD_THIRD:  rd_diff = cnt_x - XW'(3);
            RD_PEEK:   rd_diff = cnt_x - XW'(idx_reg) - XW'(1);
            default:   rd_diff = cnt_x - XW'(1);
        endcase
        unique case (cmd.wr_off)
            WR_PUSH:   wr_diff = cnt_x;
            WR_TOP:    wr_diff = cnt_x - XW'(1);
            WR_SECOND: wr_diff = cnt_x - XW'(2);
            WR_THIRD:  wr_diff = cnt_x - XW'(3);
            default:   wr_diff = cnt_x;
        endcase
    end

    assign rd_addr = rd_diff[AW-1:0];
    assign wr_addr = wr_diff[AW-1:0];

    always_comb
    begin
        acc_base = fresh ? '0 : a_reg;
        unique case (radix_reg)
            RADIX_BIN: scaled = {acc_base[WORD_BITS-2:0], 1'b0};
            RADIX_OCT: scaled = {acc_base[WORD_BITS-4:0], 3'b000};
            RADIX_DEC: scaled = {acc_base[WORD_BITS-4:0], 3'b000}
                              + {acc_base[WORD_BITS-2:0], 1'b0};
            RADIX_HEX: scaled = {acc_base[WORD_BITS-5:0], 4'b0000};
            default:   scaled = acc_base;
        endcase
        unique case (kind_reg)
            K_DIGIT:  alu = scaled + WORD_BITS'(digit_reg);
            K_ADD:    alu = b_reg + a_reg;
            K_SUB:    alu = b_reg - a_reg;
            K_AND:    alu = b_reg & a_reg;
            K_OR:     alu = b_reg | a_reg;
            K_XOR:    alu = b_reg ^ a_reg;
            K_NOT:    alu = ~a_reg;
            K_NEG:    alu = ~a_reg + 1'b1;
            K_DOUBLE: alu = {a_reg[WORD_BITS-2:0], 1'b0};
            K_HALVE:  alu = WORD_BITS'($signed(a_reg + WORD_BITS'(a_reg[WORD_BITS-1])) >>> 1);
            default:  alu = a_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.md_sel)
            MD_MUL:
            begin
                md_opa = b_reg;
                md_opb = a_reg;
                md_div = 1'b0;
            end
            MD_DIV:
            begin
                md_opa = b_reg;
                md_opb = a_reg;
                md_div = 1'b1;
            end
            MD_BKSP:
            begin
                md_opa = a_reg;
                md_opb = WORD_BITS'(radix_value(radix_reg));
                md_div = 1'b1;
            end
            default:
            begin
                md_opa = b_reg;
                md_opb = a_reg;
                md_div = 1'b0;
            end
        endcase
    end

    rpn_muldiv #(
        .WORD_BITS(WORD_BITS)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .div    (md_div),
        .opa    (md_opa),
        .opb    (md_opb),
        .busy   (md_busy),
        .result (md_result)
    );

    always_comb
    begin
        unique case (cmd.wr_src)
            SRC_A:   wr_data = a_reg;
            SRC_B:   wr_data = b_reg;
            SRC_C:   wr_data = c_reg;
            SRC_ALU: wr_data = alu;
            SRC_MD:  wr_data = md_result;
            default: wr_data = a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rzero_reg <= (rd_addr == '0) && !slot0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= cmd_kind_t'(kind);
            digit_reg <= digit_value;
            bcode_reg <= radix_code_t'(base_code);
            idx_reg   <= peek_index;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_word;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_word;
        end
        if (cmd.cap_c)
        begin
            c_reg <= rd_word;
        end
        if (cmd.cap_p)
        begin
            p_reg  <= rd_word;
            pv_reg <= (kind_reg == K_PEEK) && peek_ok;
        end
        if (cmd.out_load)
        begin
            top_value_reg   <= top_ext[31:0];
            peek_value_reg  <= peek_ext[31:0];
            peek_valid_reg  <= pv_reg;
            stack_count_reg <= count_ext[5:0];
            entering_reg    <= !closed_reg;
            beep_out_reg    <= beep_reg;
            ign_out_reg     <= ign_reg;
        end
    end

    assign top_ext   = XB'((count_reg == '0) ? '0 : rd_word);
    assign peek_ext  = XB'(pv_reg ? p_reg : '0);
    assign count_ext = XW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CW'(1);
            radix_reg     <= RADIX_DEC;
            closed_reg    <= 1'b0;
            slot0_reg     <= 1'b0;
            beep_reg      <= 1'b0;
            ign_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && wr_addr == '0)
            begin
                slot0_reg <= 1'b1;
            end
            unique case (cmd.cnt_op)
                CNT_HOLD: count_reg <= count_reg;
                CNT_INC:  count_reg <= count_reg + 1'b1;
                CNT_DEC:  count_reg <= count_reg - 1'b1;
                CNT_CLR:  count_reg <= '0;
                default:  count_reg <= count_reg;
            endcase
            if (cmd.set_closed)
            begin
                closed_reg <= 1'b1;
            end
            else if (cmd.clr_closed)
            begin
                closed_reg <= 1'b0;
            end
            if (cmd.set_radix)
            begin
                radix_reg <= bcode_reg;
            end
            if (cmd.load)
            begin
                beep_reg <= 1'b0;
                ign_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.set_beep)
                begin
                    beep_reg <= 1'b1;
                end
                if (cmd.set_ignored)
                begin
                    ign_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status           = '0;
        status.kind      = kind_reg;
        status.cnt_zero  = count_reg == '0;
        status.cnt_ge2   = count_reg >= CW'(2);
        status.cnt_ge3   = count_reg >= CW'(3);
        status.cnt_full  = full;
        status.fresh     = fresh;
        status.closed    = closed_reg;
        status.a_zero    = a_reg == '0;
        status.digit_bad = {1'b0, digit_reg} >= radix_value(radix_reg);
        status.md_busy   = md_busy;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign peek_value  = peek_value_reg;
    assign peek_valid  = peek_valid_reg;
    assign stack_count = stack_count_reg;
    assign entering    = entering_reg;
    assign beep        = beep_out_reg;
    assign ignored     = ign_out_reg;

endmodule

`default_nettype wire

// ----- hdl/rpn_ctrl.sv -----
`default_nettype none

module rpn_ctrl
    import rpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire rpn_status_t status,
    output rpn_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RA,
        S_RB,
        S_RC,
        S_RP,
        S_EX,
        S_MD,
        S_MW,
        S_W2,
        S_W3,
        S_RT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TOP;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SECOND;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd.cap_b  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_THIRD;
                state_next = S_RP;
            end
            S_RP:
            begin
                cmd.cap_c  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PEEK;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.cap_p  = 1'b1;
                state_next = S_RT;
                unique case (status.kind)
                    K_DIGIT:
                    begin
                        if (status.digit_bad)
                        begin
                            cmd.set_beep = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_src     = SRC_ALU;
                            cmd.clr_closed = 1'b1;
                            if (status.fresh)
                            begin
                                cmd.wr_off = WR_PUSH;
                                cmd.cnt_op = CNT_INC;
                            end
                            else
                            begin
                                cmd.wr_off = WR_TOP;
                            end
                        end
                    end
                    K_ENTER:
                    begin
                        if (!status.closed)
                        begin
                            cmd.set_closed = 1'b1;
                        end
                        else if (status.cnt_zero)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else if (!status.cnt_full)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_off = WR_PUSH;
                            cmd.wr_src = SRC_A;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    K_ESCAPE:
                    begin
                        if (status.closed)
                        begin
                            cmd.cnt_op = CNT_CLR;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            if (!status.cnt_zero)
                            begin
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                    end
                    K_BKSP:
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else if (status.a_zero || status.closed)
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.cnt_op     = CNT_DEC;
                        end
                        else
                        begin
                            cmd.md_start = 1'b1;
                            cmd.md_sel   = MD_BKSP;
                            state_next   = S_MD;
                        end
                    end
                    K_ADD, K_SUB, K_AND, K_OR, K_XOR:
                    begin
                        if (!status.cnt_ge2)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_off     = WR_SECOND;
                            cmd.wr_src     = SRC_ALU;
                            cmd.cnt_op     = CNT_DEC;
                        end
                    end
                    K_MUL:
                    begin
                        if (!status.cnt_ge2)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.md_start   = 1'b1;
                            cmd.md_sel     = MD_MUL;
                            state_next     = S_MD;
                        end
                    end
                    K_DIV:
                    begin
                        if (!status.cnt_ge2)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else if (status.a_zero)
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.set_beep   = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.md_start   = 1'b1;
                            cmd.md_sel     = MD_DIV;
                            state_next     = S_MD;
                        end
                    end
                    K_NOT, K_NEG, K_DOUBLE, K_HALVE:
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_off     = WR_TOP;
                            cmd.wr_src     = SRC_ALU;
                        end
                    end
                    K_SWAP:
                    begin
                        if (!status.cnt_ge2)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_off     = WR_TOP;
                            cmd.wr_src     = SRC_B;
                            state_next     = S_W2;
                        end
                    end
                    K_ROLL:
                    begin
                        if (!status.cnt_ge3)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_off     = WR_TOP;
                            cmd.wr_src     = SRC_B;
                            state_next     = S_W2;
                        end
                    end
                    K_OVER:
                    begin
                        if (!status.cnt_ge2)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else if (!status.cnt_full)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_off = WR_PUSH;
                            cmd.wr_src = SRC_B;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    K_DROP:
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                    end
                    K_DUP:
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd.set_ignored = 1'b1;
                        end
                        else
                        begin
                            cmd.set_closed = 1'b1;
                            if (!status.cnt_full)
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_off = WR_PUSH;
                                cmd.wr_src = SRC_A;
                                cmd.cnt_op = CNT_INC;
                            end
                        end
                    end
                    K_CLEAR:
                    begin
                        cmd.cnt_op     = CNT_CLR;
                        cmd.set_closed = 1'b1;
                    end
                    K_RADIX:
                    begin
                        cmd.set_radix  = 1'b1;
                        cmd.set_closed = 1'b1;
                    end
                    K_PEEK:
                    begin
                        cmd.set_ignored = 1'b0;
                    end
                    default:
                    begin
                        cmd.set_ignored = 1'b1;
                    end
                endcase
            end
            S_MD:
            begin
                if (!status.md_busy)
                begin
                    state_next = S_MW;
                end
            end
            S_MW:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_MD;
                if (status.kind == K_BKSP)
                begin
                    cmd.wr_off = WR_TOP;
                end
                else
                begin
                    cmd.wr_off = WR_SECOND;
                    cmd.cnt_op = CNT_DEC;
                end
                state_next = S_RT;
            end
            S_W2:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_off = WR_SECOND;
                if (status.kind == K_SWAP)
                begin
                    cmd.wr_src = SRC_A;
                    state_next = S_RT;
                end
                else
                begin
                    cmd.wr_src = SRC_C;
                    state_next = S_W3;
                end
            end
            S_W3:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_off = WR_THIRD;
                cmd.wr_src = SRC_A;
                state_next = S_RT;
            end
            S_RT:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TOP;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/rpn_stack_calculator_core.sv -----
`default_nettype none
// From the accepting edge the controller reads top, second, third and peek entries,
// executes, rereads the top and registers the result with out_valid, waiting while
// the output stalls; swap and roll add write states, and mul, div and open-entry
// backspace first wait for the bit-serial multiply/divide unit.
// Throughput: one command at a time; the next one is taken the cycle after
// the result is registered. Reset: stack holds one zero entry, radix ten, entry open, no result pending.

module rpn_stack_calculator_core
    import rpn_pkg::*;
#(
    parameter int STACK_ENTRIES = 32,
    parameter int WORD_BITS     = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [4:0]         kind,
    input  wire logic [3:0]         digit_value,
    input  wire logic [1:0]         base_code,
    input  wire logic [4:0]         peek_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      top_value,
    output logic signed [31:0]      peek_value,
    output logic                    peek_valid,
    output logic [5:0]              stack_count,
    output logic                    entering,
    output logic                    beep,
    output logic                    ignored
);

    rpn_cmd_t    cmd;
    rpn_status_t status;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rpn_dp #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .WORD_BITS     (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .digit_value (digit_value),
        .base_code   (base_code),
        .peek_index  (peek_index),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .top_value   (top_value),
        .peek_value  (peek_value),
        .peek_valid  (peek_valid),
        .stack_count (stack_count),
        .entering    (entering),
        .beep        (beep),
        .ignored     (ignored)
    );

endmodule

`default_nettype wire
